@@ rtl/mi4inv_pkg.sv @@
// Shared types, widths and index helpers for the 4x4 matrix inverse unit.
`default_nettype none
package mi4inv_pkg;
	localparam int ELEM_W = 32;
	localparam int COF_W = 97;
	localparam int DET_W = 131;
	localparam int QDEPTH = 2;

	typedef logic [ELEM_W-1:0] elem_t;
	typedef elem_t [3:0] row_t;
	typedef elem_t [15:0] mat_t;

	// Returns the n-th index of {0,1,2,3} with index x removed.
	function automatic logic [1:0] idx_skip(input logic [1:0] x, input logic [1:0] n);
		logic [1:0] r;
		r = (n < x) ? n : n + 2'd1;
		return r;
	endfunction
endpackage
`default_nettype wire

@@ rtl/mi4inv_front.sv @@
// Front end: collects four input rows and pushes each complete matrix into the queue.
`default_nettype none
module mi4inv_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  mi4inv_pkg::elem_t   elem_a,
	input  mi4inv_pkg::elem_t   elem_b,
	input  mi4inv_pkg::elem_t   elem_c,
	input  mi4inv_pkg::elem_t   elem_d,
	input  wire                 q_full,
	output logic                q_push,
	output mi4inv_pkg::mat_t    q_wdata
);
	import mi4inv_pkg::*;

	logic [1:0] rows_q;
	row_t       row_q [3];
	row_t       in_row;
	logic       accept;

	assign in_row   = {elem_d, elem_c, elem_b, elem_a};
	assign in_ready = (rows_q != 2'd3) || !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && (rows_q == 2'd3);
	assign q_wdata  = {in_row, row_q[2], row_q[1], row_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 2'd0;
		end else if (accept) begin
			rows_q <= rows_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (rows_q != 2'd3)) begin
			row_q[rows_q] <= in_row;
		end
	end
endmodule
`default_nettype wire

@@ rtl/mi4inv_fifo.sv @@
// Short matrix queue between the front end and the compute engine.
`default_nettype none
module mi4inv_fifo #(
	parameter int W = 512
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          push,
	input  wire [W-1:0]  wdata,
	output logic         full,
	input  wire          pop,
	output logic         valid,
	output logic [W-1:0] rdata
);
	import mi4inv_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	logic [W-1:0]  mem_q [QDEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [PW:0]   cnt_q;

	assign full  = (cnt_q == (PW+1)'(QDEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end
endmodule
`default_nettype wire

@@ rtl/mi4inv_back.sv @@
// Compute engine: cofactors, determinant and per-element division, one matrix at a time.
`default_nettype none
module mi4inv_back #(
	parameter int FRAC_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                q_valid,
	input  mi4inv_pkg::mat_t   q_rdata,
	output logic               q_pop,
	output logic               out_valid,
	input  wire                out_ready,
	output mi4inv_pkg::elem_t  inv_a,
	output mi4inv_pkg::elem_t  inv_b,
	output mi4inv_pkg::elem_t  inv_c,
	output mi4inv_pkg::elem_t  inv_d,
	output logic               singular,
	output logic               last_row
);
	import mi4inv_pkg::*;

	localparam int NW = COF_W + 2 * FRAC_BITS;
	localparam int RW = (NW > DET_W + 32) ? NW : DET_W + 32;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_COF_MUL = 9'b000000010,
		S_COF_ACC = 9'b000000100,
		S_DET_MUL = 9'b000001000,
		S_DET_ACC = 9'b000010000,
		S_DIV_SET = 9'b000100000,
		S_DIV_IT  = 9'b001000000,
		S_DIV_END = 9'b010000000,
		S_OUT     = 9'b100000000
	} state_t;

	state_t                    state_q;
	mat_t                      m_q;
	logic [3:0]                kidx_q;
	logic [1:0]                t_q;
	logic [1:0]                p_q;
	logic signed [65:0]        prod_q;
	logic signed [64:0]        minor_q;
	logic signed [COF_W-1:0]   acc_q;
	logic [COF_W-1:0]          cof_q [16];
	logic signed [DET_W-1:0]   det_q;
	logic [RW-1:0]             rem_q;
	logic [RW-1:0]             dsh_q;
	logic [31:0]               quo_q;
	logic [4:0]                bit_q;
	logic                      big_q;
	logic                      neg_q;
	elem_t                     res_q [4];
	logic                      out_valid_q;
	elem_t                     inv_q [4];
	logic                      sing_q;
	logic                      last_q;

	logic [1:0]                ci, cj, rs0, rs1, rs2, ct, cu, cv;
	logic signed [32:0]        mul_a, mul_b;
	logic signed [65:0]        prod;
	logic [3:0]                rd_idx;
	logic [COF_W-1:0]          cof_rd;
	logic [COF_W-1:0]          cabs;
	logic [DET_W-1:0]          dabs;
	logic [RW-1:0]             nabs_w;
	logic [RW-1:0]             dabs_w;
	logic                      sing;
	logic                      term_neg;
	logic signed [COF_W-1:0]   cterm;
	logic signed [DET_W-1:0]   dterm;
	logic                      rem_ge;
	elem_t                     div_val;

	function automatic elem_t el(input mat_t m, input logic [1:0] r, input logic [1:0] c);
		return m[{r, c}];
	endfunction

	// Sign-extends one element to the multiplier operand width.
	function automatic logic signed [32:0] sx(input elem_t e);
		return $signed({e[31], e});
	endfunction

	assign ci  = kidx_q[3:2];
	assign cj  = kidx_q[1:0];
	assign rs0 = idx_skip(ci, 2'd0);
	assign rs1 = idx_skip(ci, 2'd1);
	assign rs2 = idx_skip(ci, 2'd2);
	assign ct  = idx_skip(cj, t_q);
	assign cu  = idx_skip(cj, (t_q == 2'd0) ? 2'd1 : 2'd0);
	assign cv  = idx_skip(cj, (t_q == 2'd2) ? 2'd1 : 2'd2);

	assign rd_idx = (state_q == S_DET_MUL) ? {2'b00, kidx_q[1:0]} : {kidx_q[1:0], kidx_q[3:2]};
	assign cof_rd = cof_q[rd_idx];
	assign cabs   = cof_rd[COF_W-1] ? (~cof_rd + 1'b1) : cof_rd;
	assign dabs   = det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);
	assign nabs_w = RW'(cabs) << (2 * FRAC_BITS);
	assign dabs_w = RW'(dabs);
	assign sing   = (det_q == '0);
	assign rem_ge = (rem_q >= dsh_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_COF_MUL) begin
			unique case (p_q)
				2'd0: begin
					mul_a = sx(el(m_q, rs1, cu));
					mul_b = sx(el(m_q, rs2, cv));
				end
				2'd1: begin
					mul_a = sx(el(m_q, rs1, cv));
					mul_b = sx(el(m_q, rs2, cu));
				end
				2'd2: begin
					mul_a = sx(el(m_q, rs0, ct));
					mul_b = $signed({1'b0, minor_q[31:0]});
				end
				default: begin
					mul_a = sx(el(m_q, rs0, ct));
					mul_b = $signed(minor_q[64:32]);
				end
			endcase
		end else if (state_q == S_DET_MUL) begin
			mul_a = sx(el(m_q, 2'd0, cj));
			unique case (p_q)
				2'd0:    mul_b = $signed({1'b0, cof_rd[31:0]});
				2'd1:    mul_b = $signed({1'b0, cof_rd[63:32]});
				default: mul_b = $signed(cof_rd[96:64]);
			endcase
		end
	end

	assign prod = mul_a * mul_b;

	assign term_neg = (t_q == 2'd1) ^ ci[0] ^ cj[0];
	assign cterm = (p_q == 2'd3) ? (COF_W'(prod_q) <<< 32) : COF_W'(prod_q);
	always_comb begin
		unique case (p_q)
			2'd0:    dterm = DET_W'(prod_q);
			2'd1:    dterm = DET_W'(prod_q) <<< 32;
			default: dterm = DET_W'(prod_q) <<< 64;
		endcase
	end

	always_comb begin
		if (sing) begin
			div_val = '0;
		end else if (!neg_q) begin
			div_val = (big_q || quo_q[31]) ? 32'h7FFF_FFFF : quo_q;
		end else begin
			div_val = (big_q || (quo_q[31] && (quo_q[30:0] != '0))) ? 32'h8000_0000 : (~quo_q + 1'b1);
		end
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kidx_q      <= '0;
			t_q         <= '0;
			p_q         <= '0;
			bit_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						kidx_q  <= '0;
						t_q     <= '0;
						p_q     <= '0;
						state_q <= S_COF_MUL;
					end
				end
				S_COF_MUL: state_q <= S_COF_ACC;
				S_COF_ACC: begin
					p_q     <= p_q + 2'd1;
					state_q <= S_COF_MUL;
					if (p_q == 2'd3) begin
						if (t_q == 2'd2) begin
							t_q <= '0;
							kidx_q <= kidx_q + 4'd1;
							if (kidx_q == 4'd15) begin
								state_q <= S_DET_MUL;
							end
						end else begin
							t_q <= t_q + 2'd1;
						end
					end
				end
				S_DET_MUL: state_q <= S_DET_ACC;
				S_DET_ACC: begin
					state_q <= S_DET_MUL;
					if (p_q == 2'd2) begin
						p_q    <= '0;
						kidx_q <= kidx_q + 4'd1;
						if (kidx_q[1:0] == 2'd3) begin
							kidx_q  <= '0;
							state_q <= S_DIV_SET;
						end
					end else begin
						p_q <= p_q + 2'd1;
					end
				end
				S_DIV_SET: begin
					bit_q <= 5'd31;
					if (sing || (nabs_w >= (dabs_w << 32))) begin
						state_q <= S_DIV_END;
					end else begin
						state_q <= S_DIV_IT;
					end
				end
				S_DIV_IT: begin
					bit_q <= bit_q - 5'd1;
					if (bit_q == 5'd0) begin
						state_q <= S_DIV_END;
					end
				end
				S_DIV_END: begin
					if (kidx_q[1:0] == 2'd3) begin
						state_q <= S_OUT;
					end else begin
						kidx_q  <= kidx_q + 4'd1;
						state_q <= S_DIV_SET;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						kidx_q      <= kidx_q + 4'd1;
						state_q     <= (kidx_q == 4'd15) ? S_IDLE : S_DIV_SET;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					m_q   <= q_rdata;
					acc_q <= '0;
					det_q <= '0;
				end
			end
			S_COF_MUL: prod_q <= prod;
			S_COF_ACC: begin
				unique case (p_q)
					2'd0: minor_q <= 65'(prod_q);
					2'd1: minor_q <= minor_q - 65'(prod_q);
					default: begin
						if ((p_q == 2'd3) && (t_q == 2'd2)) begin
							cof_q[kidx_q] <= term_neg ? (acc_q - cterm) : (acc_q + cterm);
							acc_q <= '0;
						end else begin
							acc_q <= term_neg ? (acc_q - cterm) : (acc_q + cterm);
						end
					end
				endcase
			end
			S_DET_MUL: prod_q <= prod;
			S_DET_ACC: det_q <= det_q + dterm;
			S_DIV_SET: begin
				rem_q <= nabs_w;
				dsh_q <= dabs_w << 31;
				quo_q <= '0;
				big_q <= (nabs_w >= (dabs_w << 32));
				neg_q <= cof_rd[COF_W-1] ^ det_q[DET_W-1];
			end
			S_DIV_IT: begin
				if (rem_ge) begin
					rem_q <= rem_q - dsh_q;
				end
				quo_q <= {quo_q[30:0], rem_ge};
				dsh_q <= dsh_q >> 1;
			end
			S_DIV_END: res_q[kidx_q[1:0]] <= div_val;
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					inv_q[0] <= res_q[0];
					inv_q[1] <= res_q[1];
					inv_q[2] <= res_q[2];
					inv_q[3] <= res_q[3];
					sing_q   <= sing;
					last_q   <= (kidx_q[3:2] == 2'd3);
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign inv_a     = inv_q[0];
	assign inv_b     = inv_q[1];
	assign inv_c     = inv_q[2];
	assign inv_d     = inv_q[3];
	assign singular  = sing_q;
	assign last_row  = last_q;
endmodule
`default_nettype wire

@@ rtl/matrix4_inverse_unit.sv @@
// Top level of the fixed-point 4x4 matrix inverse unit.
// A matrix enters as four row transactions and leaves as four inverse row transactions,
// the last flagged by last_row; singular is set, with zero elements, when the determinant
// is zero. All cofactors and the determinant are exact; each inverse element is
// truncated toward zero and saturated to 32 bits. One shared 33x33 multiplier forms the
// cofactors and determinant, and a restoring divider then forms each element, skipping
// its iterations when the matrix is singular or the element saturates.
// A two-entry matrix queue lets new rows be collected while the engine works.
`default_nettype none
module matrix4_inverse_unit #(
	parameter int FRAC_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  mi4inv_pkg::elem_t  elem_a,
	input  mi4inv_pkg::elem_t  elem_b,
	input  mi4inv_pkg::elem_t  elem_c,
	input  mi4inv_pkg::elem_t  elem_d,
	output logic               out_valid,
	input  wire                out_ready,
	output mi4inv_pkg::elem_t  inv_a,
	output mi4inv_pkg::elem_t  inv_b,
	output mi4inv_pkg::elem_t  inv_c,
	output mi4inv_pkg::elem_t  inv_d,
	output logic               singular,
	output logic               last_row
);
	import mi4inv_pkg::*;

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_valid;
	mat_t q_wdata;
	mat_t q_rdata;

	mi4inv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.elem_a   (elem_a),
		.elem_b   (elem_b),
		.elem_c   (elem_c),
		.elem_d   (elem_d),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	mi4inv_fifo #(.W($bits(mat_t))) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	mi4inv_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.inv_a     (inv_a),
		.inv_b     (inv_b),
		.inv_c     (inv_c),
		.inv_d     (inv_d),
		.singular  (singular),
		.last_row  (last_row)
	);
endmodule
`default_nettype wire

@@ rtl/mi4inv_checker.sv @@
// Port-level checks for the matrix inverse unit and their binding to the top level.
`default_nettype none
module mi4inv_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                in_valid,
	input wire                in_ready,
	input mi4inv_pkg::elem_t  elem_a,
	input mi4inv_pkg::elem_t  elem_b,
	input mi4inv_pkg::elem_t  elem_c,
	input mi4inv_pkg::elem_t  elem_d,
	input wire                out_valid,
	input wire                out_ready,
	input mi4inv_pkg::elem_t  inv_a,
	input mi4inv_pkg::elem_t  inv_b,
	input mi4inv_pkg::elem_t  inv_c,
	input mi4inv_pkg::elem_t  inv_d,
	input wire                singular,
	input wire                last_row
);
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("Result transaction offered during reset.");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> (inv_a == '0) && (inv_b == '0) && (inv_c == '0) && (inv_d == '0))
		else $error("Singular result carries nonzero elements.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(inv_a) && $stable(inv_b)
			&& $stable(inv_c) && $stable(inv_d) && $stable(singular) && $stable(last_row))
		else $error("Stalled result transaction changed.");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(elem_a) && $stable(elem_b)
			&& $stable(elem_c) && $stable(elem_d))
		else $error("Stalled input transaction changed.");

	a_no_row_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("Result appeared without any input rows.");
endmodule

bind matrix4_inverse_unit mi4inv_checker u_chk (.*);
`default_nettype wire

@@ dv/tb_matrix4_inverse_unit.sv @@
// Self-checking testbench for the 4x4 fixed-point matrix inverse unit.
`default_nettype none
class inverse_scoreboard;
	logic [31:0] rows_seen [16];
	int rows_in;
	logic [131:0] exp_q [$];
	int mismatches;
	int reported;

	function new();
		rows_in = 0;
		mismatches = 0;
		reported = 0;
	endfunction

	function automatic logic signed [255:0] entry(int r, int c);
		logic signed [31:0] v;
		v = rows_seen[r * 4 + c];
		return v;
	endfunction

	function automatic logic signed [255:0] minor3(int row, int col);
		int rs [3];
		int cs [3];
		int k;
		int j;
		logic signed [255:0] m [3][3];
		logic signed [255:0] d;
		k = 0;
		for (j = 0; j < 4; j++) if (j != row) begin
			rs[k] = j;
			k++;
		end
		k = 0;
		for (j = 0; j < 4; j++) if (j != col) begin
			cs[k] = j;
			k++;
		end
		for (int a = 0; a < 3; a++)
			for (int b = 0; b < 3; b++) m[a][b] = entry(rs[a], cs[b]);
		d = m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
			- m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
			+ m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
		return ((row + col) % 2 == 1) ? -d : d;
	endfunction

	function automatic logic [31:0] sat_quotient(logic signed [255:0] num,
			logic signed [255:0] den);
		logic signed [255:0] q;
		q = num / den;
		if (q > 256'sd2147483647) return 32'h7FFFFFFF;
		if (q < -256'sd2147483648) return 32'h80000000;
		return q[31:0];
	endfunction

	function void note_row(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
		logic signed [255:0] adj [16];
		logic signed [255:0] det;
		logic [127:0] vals;
		logic sing;
		rows_seen[rows_in * 4 + 0] = a;
		rows_seen[rows_in * 4 + 1] = b;
		rows_seen[rows_in * 4 + 2] = c;
		rows_seen[rows_in * 4 + 3] = d;
		if (rows_in != 3) begin
			rows_in++;
			return;
		end
		rows_in = 0;
		for (int r = 0; r < 4; r++)
			for (int cc = 0; cc < 4; cc++) adj[r * 4 + cc] = minor3(cc, r);
		det = 0;
		for (int cc = 0; cc < 4; cc++) det += entry(0, cc) * adj[cc * 4];
		sing = (det == 0);
		for (int r = 0; r < 4; r++) begin
			vals = '0;
			for (int cc = 0; cc < 4; cc++)
				if (!sing) vals[127 - 32 * cc -: 32] = sat_quotient(adj[r * 4 + cc] <<< 32, det);
			exp_q.push_back({vals, 2'b00, sing, r == 3});
		end
	endfunction

	function void check_row(logic [131:0] got);
		logic [131:0] want;
		if (exp_q.size() == 0) begin
			mismatches++;
			if (reported < 10) begin
				reported++;
				$display("unexpected result transaction %h", got);
			end
			return;
		end
		want = exp_q.pop_front();
		if (got !== want) begin
			mismatches++;
			if (reported < 10) begin
				reported++;
				$display("mismatch: expected %h actual %h", want, got);
			end
		end
	endfunction
endclass

module tb_matrix4_inverse_unit;
	import mi4inv_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic out_ready = 0;
	elem_t elem_a = '0, elem_b = '0, elem_c = '0, elem_d = '0;
	logic in_ready, out_valid, singular, last_row;
	elem_t inv_a, inv_b, inv_c, inv_d;

	inverse_scoreboard sb = new();
	int idle_cycles = 0;
	bit long_hold = 0;
	bit stim_done = 0;

	matrix4_inverse_unit u_dut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.note_row(elem_a, elem_b, elem_c, elem_d);
		if (out_valid && out_ready)
			sb.check_row({inv_a, inv_b, inv_c, inv_d, 2'b00, singular, last_row});
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) if (idle_cycles > 20000) begin
		$display("*** FAILED ***");
		$finish;
	end

	function automatic elem_t pick_elem(int mode);
		case (mode)
			0: return $urandom();
			1: return $urandom_range(0, 6) * 32'sh10000 - 32'sh30000;
			2: return $signed($urandom_range(0, 400000)) - 200000;
			default: return $urandom_range(0, 3) == 0 ? 32'h80000000 : 32'h7FFFFFFF;
		endcase
	endfunction

	task automatic send_row(elem_t a, elem_t b, elem_t c, elem_t d, bit gaps);
		int wait_n;
		wait_n = gaps ? $urandom_range(0, 9) : 0;
		if (wait_n > 0) begin
			in_valid <= 0;
			repeat (wait_n) @(posedge clk);
		end
		in_valid <= 1;
		elem_a <= a;
		elem_b <= b;
		elem_c <= c;
		elem_d <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_matrix(int mode, bit gaps);
		for (int r = 0; r < 4; r++)
			send_row(pick_elem(mode), pick_elem(mode), pick_elem(mode), pick_elem(mode), gaps);
	endtask

	initial begin
		int wait_n;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		forever begin
			if (long_hold) begin
				out_ready <= 0;
				repeat (3000) @(posedge clk);
				long_hold = 0;
			end
			wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
			if (wait_n > 0) begin
				out_ready <= 0;
				repeat (wait_n) @(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		elem_t one;
		one = 32'h10000;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		send_row(one, 0, 0, 0, 0);
		send_row(0, one, 0, 0, 0);
		send_row(0, 0, one, 0, 0);
		send_row(0, 0, 0, one, 0);
		send_row(2, 0, 0, 0, 0);
		send_row(0, 2, 0, 0, 0);
		send_row(0, 0, 32'hFFFFFFFE, 0, 0);
		send_row(0, 0, 0, 1, 0);
		send_row(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 0, 0);
		send_row(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 0, 0);
		send_row(1, 2, 3, 4, 0);
		send_row(5, 6, 7, 8, 0);
		send_row(32'h80000000, 0, 0, 0, 0);
		send_row(0, 32'h7FFFFFFF, 0, 0, 0);
		send_row(0, 0, 32'h80000000, 0, 0);
		send_row(0, 0, 0, 32'h7FFFFFFF, 0);
		long_hold = 1;
		for (int m = 0; m < 3; m++) send_matrix(1, 0);
		in_valid <= 0;
		@(posedge clk);
		wait (sb.exp_q.size() == 0);
		for (int m = 0; m < 48; m++) send_matrix($urandom_range(0, 3), 1);
		in_valid <= 0;
		@(posedge clk);
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		wait (sb.exp_q.size() == 0);
		repeat (2000) @(posedge clk);
		if (sb.mismatches == 0 && sb.exp_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/mi4inv_pkg.sv
rtl/mi4inv_front.sv
rtl/mi4inv_fifo.sv
rtl/mi4inv_back.sv
rtl/matrix4_inverse_unit.sv
rtl/mi4inv_checker.sv
dv/tb_matrix4_inverse_unit.sv
